/* sv/tas_pkg.sv */
// ----------------------------------------------------------------------------
// tas_pkg: shared types, constants and the table function
// Register indexes, reset values, datapath command and status structs, and
// the constant function that builds the exponential table.
// ----------------------------------------------------------------------------
package tas_pkg;

  // default sizes
  localparam int EXP_DEPTH_DEF = 256;
  localparam int OUT_WIDTH_DEF = 18;

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_ADDR_W-1:0] CFG_PEAK_MULT    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ACCEL_WINDOW = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SMOOTH_GAIN  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SWITCH_MASK  = 2'd3;

  localparam logic [7:0] PEAK_MULT_RST    = 8'd25;
  localparam logic [7:0] ACCEL_WINDOW_RST = 8'd5;
  localparam logic [9:0] SMOOTH_GAIN_RST  = 10'd333;
  localparam logic [7:0] SWITCH_MASK_RST  = 8'd128;

  // datapath widths
  localparam int MUL_A_W    = 17;  // peak_mult-1, deltas, alpha, 256-alpha
  localparam int SCALED_W   = 18;  // delta times gain over 256
  localparam int GAIN_W     = 17;  // Q9.8 gain
  localparam int ENTRY_W    = 9;   // Q1.8 table entry, exp(0) = 256

  localparam logic [63:0] Q31 = 64'h0000_0000_8000_0000;

  // operand pair for the shared multiplier
  typedef enum logic [2:0] {
    MS_GAIN,  // (peak_mult - 1) * entry
    MS_X,     // dx * gain
    MS_Y,     // dy * gain
    MS_AX,    // alpha * scaled x
    MS_BX,    // (256 - alpha) * previous x
    MS_AY,    // alpha * scaled y
    MS_BY     // (256 - alpha) * previous y
  } mul_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     load;
    logic     div_step;
    logic     rom_rd;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     gain_ld;
    logic     sx_ld;
    logic     sy_ld;
    logic     acc_ld;
    logic     nx_ld;
    logic     ny_ld;
    logic     commit;
  } tas_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic move;
    logic out_free;
  } tas_stat_t;

  // exp(-16y) in Q1.8 from y in Q31: series for exp(-y) to order 8, then squared four times
  function automatic logic [ENTRY_W-1:0] exp_q8(input logic [63:0] y);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = Q31;
    term = Q31;
    for (int k = 1; k <= 8; k++) begin
      term = (term * y) >> 31;
      case (k)
        2:       term = term / 2;
        3:       term = term / 3;
        4:       term = term / 4;
        5:       term = term / 5;
        6:       term = term / 6;
        7:       term = term / 7;
        8:       term = term / 8;
        default: term = term;
      endcase
      if ((k & 1) != 0) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    for (int s = 0; s < 4; s++) begin
      sum = (sum * sum) >> 31;
    end
    return ENTRY_W'((sum + 64'h0000_0000_0040_0000) >> 23);
  endfunction

endpackage

/* sv/tas_exp_rom.sv */
// ----------------------------------------------------------------------------
// tas_exp_rom: exponential decay table
// Constant table of exp(-3i/depth) in Q1.8, built at elaboration, with a
// registered read port. Out-of-range indexes read the last entry.
// ----------------------------------------------------------------------------
module tas_exp_rom #(
  parameter int EXP_TABLE_DEPTH = tas_pkg::EXP_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rd,
  input  logic [$clog2(EXP_TABLE_DEPTH)-1:0] idx,
  output logic [tas_pkg::ENTRY_W-1:0]    entry
);

  localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);

  logic [tas_pkg::ENTRY_W-1:0] rom_c [EXP_TABLE_DEPTH];
  logic [IDX_W-1:0]            idx_c;
  logic [tas_pkg::ENTRY_W-1:0] entry_r;

  // table contents
  for (genvar i = 0; i < EXP_TABLE_DEPTH; i++) begin : g_rom
    localparam logic [63:0] Y = (64'd3 * 64'(i) * tas_pkg::Q31) /
                                (64'd16 * 64'(EXP_TABLE_DEPTH));
    localparam logic [tas_pkg::ENTRY_W-1:0] ENTRY = tas_pkg::exp_q8(Y);
    assign rom_c[i] = ENTRY;
  end

  // clamp for depths that are not a power of two
  always_comb begin
    if ({1'b0, idx} >= (IDX_W+1)'(EXP_TABLE_DEPTH)) begin
      idx_c = IDX_W'(EXP_TABLE_DEPTH - 1);
    end else begin
      idx_c = idx;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd) begin
      entry_r <= rom_c[idx_c];
    end
  end

  assign entry = entry_r;

endmodule

/* sv/tas_div.sv */
// ----------------------------------------------------------------------------
// tas_div: table index divider
// Restoring divider, one quotient bit per step: (t * depth) / window.
// The quotient is only meaningful when t < window.
// ----------------------------------------------------------------------------
module tas_div #(
  parameter int EXP_TABLE_DEPTH = tas_pkg::EXP_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               start,
  input  logic                               step,
  input  logic [7:0]                         t,
  input  logic [7:0]                         window,
  output logic [$clog2(EXP_TABLE_DEPTH)-1:0] quot
);

  localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
  localparam int NUM_W = 8 + IDX_W;

  logic [7:0]       rem_r, rem_nxt;
  logic [IDX_W-1:0] lq_r, lq_nxt;
  logic [NUM_W-1:0] num_c;
  logic [8:0]       trial_c;
  logic [8:0]       diff_c;
  logic             ge_c;

  assign num_c = NUM_W'(t) * NUM_W'(EXP_TABLE_DEPTH);

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial_c = {rem_r, lq_r[IDX_W-1]};
    ge_c    = trial_c >= {1'b0, window};
    diff_c  = trial_c - {1'b0, window};
    rem_nxt = rem_r;
    lq_nxt  = lq_r;
    if (start) begin
      rem_nxt = num_c[NUM_W-1:IDX_W];
      lq_nxt  = num_c[IDX_W-1:0];
    end else if (step) begin
      rem_nxt = ge_c ? diff_c[7:0] : trial_c[7:0];
      lq_nxt  = {lq_r[IDX_W-2:0], ge_c};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    lq_r  <= lq_nxt;
  end

  assign quot = lq_r;

endmodule

/* sv/tas_datapath.sv */
// ----------------------------------------------------------------------------
// tas_datapath: acceleration and smoothing datapath
// Configuration registers, input capture, index divider, exponential table,
// one shared signed multiplier, smoothing state and the output register.
// ----------------------------------------------------------------------------
module tas_datapath #(
  parameter int EXP_TABLE_DEPTH = tas_pkg::EXP_DEPTH_DEF,
  parameter int OUT_WIDTH       = tas_pkg::OUT_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_we,
  input  logic [tas_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [tas_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  // input payload
  input  logic [7:0]                           in_left_count,
  input  logic [7:0]                           in_right_count,
  input  logic [7:0]                           in_up_count,
  input  logic [7:0]                           in_down_count,
  input  logic [7:0]                           in_status_byte,
  input  logic [15:0]                          in_elapsed_time,
  // control
  input  tas_pkg::tas_cmd_t                    cmd,
  output tas_pkg::tas_stat_t                   stat,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_x_valid,
  output logic signed [OUT_WIDTH-1:0]          out_x_motion,
  output logic                                 out_y_valid,
  output logic signed [OUT_WIDTH-1:0]          out_y_motion,
  output logic                                 out_button_changed,
  output logic                                 out_button_pressed
);

  localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
  localparam int AW    = tas_pkg::MUL_A_W;
  localparam int SW    = tas_pkg::SCALED_W;
  localparam int BW    = (OUT_WIDTH > SW) ? OUT_WIDTH : SW;
  localparam int PW    = AW + BW;
  localparam logic signed [PW:0] SAT_MAX =
    {{(PW + 2 - OUT_WIDTH){1'b0}}, {(OUT_WIDTH - 1){1'b1}}};
  localparam logic signed [PW:0] SAT_MIN = ~SAT_MAX;

  // configuration registers
  logic [7:0] peak_mult_r;
  logic [7:0] accel_window_r;
  logic [9:0] smoothing_gain_r;
  logic [7:0] switch_mask_r;

  // captured item
  logic signed [8:0] dx_r, dy_r;
  logic              move_r, accel_r;
  logic              pressed_r, changed_r;
  logic              last_button_r;

  // arithmetic
  logic [tas_pkg::ENTRY_W-1:0]  entry_c;
  logic [IDX_W-1:0]             quot_c;
  logic signed [AW-1:0]         mul_a_c;
  logic signed [BW-1:0]         mul_b_c;
  logic signed [PW-1:0]         prod_r, acc_r;
  logic [tas_pkg::GAIN_W-1:0]   gain_r;
  logic signed [SW-1:0]         sx_r, sy_r;
  logic signed [OUT_WIDTH-1:0]  nx_r, ny_r;
  logic signed [OUT_WIDTH-1:0]  last_x_r, last_y_r;
  logic signed [PW-1:0]         sc_rnd_c, sc_c;
  logic signed [PW:0]           sum_c, sum_rnd_c, sum_q_c;
  logic signed [OUT_WIDTH-1:0]  sat_c;
  logic signed [AW-1:0]         alpha_c, beta_c, speed_m1_c;

  // output register
  logic                         out_valid_r;
  logic                         out_x_valid_r, out_y_valid_r;
  logic signed [OUT_WIDTH-1:0]  out_x_r, out_y_r;
  logic                         out_changed_r, out_pressed_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_mult_r      <= tas_pkg::PEAK_MULT_RST;
      accel_window_r   <= tas_pkg::ACCEL_WINDOW_RST;
      smoothing_gain_r <= tas_pkg::SMOOTH_GAIN_RST;
      switch_mask_r    <= tas_pkg::SWITCH_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        tas_pkg::CFG_PEAK_MULT:    peak_mult_r      <= cfg_wdata[7:0];
        tas_pkg::CFG_ACCEL_WINDOW: accel_window_r   <= cfg_wdata[7:0];
        tas_pkg::CFG_SMOOTH_GAIN:  smoothing_gain_r <= cfg_wdata;
        tas_pkg::CFG_SWITCH_MASK:  switch_mask_r    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // switch tracking, updated on every transfer in
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_button_r <= 1'b0;
    end else if (cmd.load) begin
      last_button_r <= |(in_status_byte & switch_mask_r);
    end
  end

  // capture the item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx_r      <= $signed({1'b0, in_right_count}) - $signed({1'b0, in_left_count});
      dy_r      <= $signed({1'b0, in_down_count}) - $signed({1'b0, in_up_count});
      move_r    <= (in_right_count != in_left_count) || (in_down_count != in_up_count);
      accel_r   <= in_elapsed_time < {8'd0, accel_window_r};
      pressed_r <= |(in_status_byte & switch_mask_r);
      changed_r <= (|(in_status_byte & switch_mask_r)) != last_button_r;
    end
  end

  // table index and table read
  tas_div #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_div (
    .clk    (clk),
    .start  (cmd.load),
    .step   (cmd.div_step),
    .t      (in_elapsed_time[7:0]),
    .window (accel_window_r),
    .quot   (quot_c)
  );

  tas_exp_rom #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_rom (
    .clk   (clk),
    .rd    (cmd.rom_rd),
    .idx   (quot_c),
    .entry (entry_c)
  );

  // multiplier operand select
  assign speed_m1_c = AW'($signed({1'b0, peak_mult_r})) - AW'(1);
  assign alpha_c    = AW'($signed({1'b0, smoothing_gain_r}));
  assign beta_c     = AW'(256) - alpha_c;

  always_comb begin
    case (cmd.mul_sel)
      tas_pkg::MS_GAIN: begin
        mul_a_c = speed_m1_c;
        mul_b_c = BW'($signed({1'b0, entry_c}));
      end
      tas_pkg::MS_X: begin
        mul_a_c = AW'(dx_r);
        mul_b_c = BW'($signed({1'b0, gain_r}));
      end
      tas_pkg::MS_Y: begin
        mul_a_c = AW'(dy_r);
        mul_b_c = BW'($signed({1'b0, gain_r}));
      end
      tas_pkg::MS_AX: begin
        mul_a_c = alpha_c;
        mul_b_c = BW'(sx_r);
      end
      tas_pkg::MS_BX: begin
        mul_a_c = beta_c;
        mul_b_c = BW'(last_x_r);
      end
      tas_pkg::MS_AY: begin
        mul_a_c = alpha_c;
        mul_b_c = BW'(sy_r);
      end
      tas_pkg::MS_BY: begin
        mul_a_c = beta_c;
        mul_b_c = BW'(last_y_r);
      end
      default: begin
        mul_a_c = '0;
        mul_b_c = '0;
      end
    endcase
  end

  // shared multiplier, product registered
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= mul_a_c * mul_b_c;
    end
  end

  // scaled delta: product over 256, truncated toward zero
  assign sc_rnd_c = prod_r + (prod_r[PW-1] ? PW'(255) : PW'(0));
  assign sc_c     = sc_rnd_c >>> 8;

  // smoothed value: sum over 256 toward zero, then saturate
  assign sum_c     = {acc_r[PW-1], acc_r} + {prod_r[PW-1], prod_r};
  assign sum_rnd_c = sum_c + (sum_c[PW] ? (PW+1)'(255) : (PW+1)'(0));
  assign sum_q_c   = sum_rnd_c >>> 8;

  always_comb begin
    if (sum_q_c > SAT_MAX) begin
      sat_c = SAT_MAX[OUT_WIDTH-1:0];
    end else if (sum_q_c < SAT_MIN) begin
      sat_c = SAT_MIN[OUT_WIDTH-1:0];
    end else begin
      sat_c = sum_q_c[OUT_WIDTH-1:0];
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.gain_ld) begin
      gain_r <= accel_r ? (prod_r[tas_pkg::GAIN_W-1:0] + tas_pkg::GAIN_W'(256))
                        : tas_pkg::GAIN_W'(256);
    end
    if (cmd.sx_ld) begin
      sx_r <= sc_c[SW-1:0];
    end
    if (cmd.sy_ld) begin
      sy_r <= sc_c[SW-1:0];
    end
    if (cmd.acc_ld) begin
      acc_r <= prod_r;
    end
    if (cmd.nx_ld) begin
      nx_r <= sat_c;
    end
    if (cmd.ny_ld) begin
      ny_r <= sat_c;
    end
  end

  // previous outputs, kept when there is no movement
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r <= '0;
      last_y_r <= '0;
    end else if (cmd.commit && move_r) begin
      last_x_r <= nx_r;
      last_y_r <= ny_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_x_valid_r <= dx_r != '0;
      out_y_valid_r <= dy_r != '0;
      out_x_r       <= (dx_r != '0) ? nx_r : '0;
      out_y_r       <= (dy_r != '0) ? ny_r : '0;
      out_changed_r <= changed_r;
      out_pressed_r <= pressed_r;
    end
  end

  assign stat.move     = move_r;
  assign stat.out_free = !out_valid_r || !out_stall;

  assign out_valid          = out_valid_r;
  assign out_x_valid        = out_x_valid_r;
  assign out_x_motion       = out_x_r;
  assign out_y_valid        = out_y_valid_r;
  assign out_y_motion       = out_y_r;
  assign out_button_changed = out_changed_r;
  assign out_button_pressed = out_pressed_r;

endmodule

/* sv/tas_ctrl.sv */
// ----------------------------------------------------------------------------
// tas_ctrl: sequencer
// One-hot state machine that steps the datapath through divide, table read,
// gain, scaling and smoothing for one item at a time.
// ----------------------------------------------------------------------------
module tas_ctrl #(
  parameter int EXP_TABLE_DEPTH = tas_pkg::EXP_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tas_pkg::tas_stat_t stat,
  output tas_pkg::tas_cmd_t  cmd
);

  localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
  localparam int CW    = (IDX_W > 1) ? $clog2(IDX_W) : 1;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_DIV  = 13'b0000000000010,
    S_ROM  = 13'b0000000000100,
    S_GMUL = 13'b0000000001000,
    S_GAIN = 13'b0000000010000,
    S_XMUL = 13'b0000000100000,
    S_YMUL = 13'b0000001000000,
    S_SXA  = 13'b0000010000000,
    S_SXB  = 13'b0000100000000,
    S_SXC  = 13'b0001000000000,
    S_SYB  = 13'b0010000000000,
    S_SYC  = 13'b0100000000000,
    S_DONE = 13'b1000000000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // state and divide step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    cmd.mul_sel = tas_pkg::MS_GAIN;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CW'(1);
        if (cnt_r == CW'(IDX_W - 1)) begin
          state_nxt = stat.move ? S_ROM : S_DONE;
        end
      end
      S_ROM: begin
        cmd.rom_rd = 1'b1;
        state_nxt  = S_GMUL;
      end
      S_GMUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_GAIN;
      end
      S_GAIN: begin
        cmd.gain_ld = 1'b1;
        state_nxt   = S_XMUL;
      end
      S_XMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tas_pkg::MS_X;
        state_nxt   = S_YMUL;
      end
      S_YMUL: begin
        cmd.sx_ld   = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tas_pkg::MS_Y;
        state_nxt   = S_SXA;
      end
      S_SXA: begin
        cmd.sy_ld   = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tas_pkg::MS_AX;
        state_nxt   = S_SXB;
      end
      S_SXB: begin
        cmd.acc_ld  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tas_pkg::MS_BX;
        state_nxt   = S_SXC;
      end
      S_SXC: begin
        cmd.nx_ld   = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tas_pkg::MS_AY;
        state_nxt   = S_SYB;
      end
      S_SYB: begin
        cmd.acc_ld  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tas_pkg::MS_BY;
        state_nxt   = S_SYC;
      end
      S_SYC: begin
        cmd.ny_ld = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // wait for room in the output register
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = state_r != S_IDLE;

endmodule

/* sv/trackball_accel_smoother.sv */
// ----------------------------------------------------------------------------
// trackball_accel_smoother: pointer acceleration with exponential smoothing
// Per poll: deltas from four direction counts, time-dependent gain from an
// exponential table, per-axis smoothing with saturation, switch change flag.
//
//   channel   handshake            payload
//   in_       in_valid / in_stall  four counts, status byte, elapsed time
//   out_      out_valid/out_stall  x/y valid and motion, button flags
//   cfg_      cfg_we               cfg_addr selects register, cfg_wdata
//
// An item passes from transfer in to result through the bit-serial table index
// divider (IDX_W steps) and the single shared multiplier, used seven times in
// sequence. No-movement items skip the table read and the multiply steps.
// Reset is synchronous; there is no clearing pass.
// A result waits in the output register while out_stall is high; the next
// item is taken meanwhile and holds in its final step until the register frees.
// ----------------------------------------------------------------------------
module trackball_accel_smoother #(
  parameter int EXP_TABLE_DEPTH = tas_pkg::EXP_DEPTH_DEF,
  parameter int OUT_WIDTH       = tas_pkg::OUT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic [tas_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tas_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_left_count,
  input  logic [7:0]                     in_right_count,
  input  logic [7:0]                     in_up_count,
  input  logic [7:0]                     in_down_count,
  input  logic [7:0]                     in_status_byte,
  input  logic [15:0]                    in_elapsed_time,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_x_valid,
  output logic signed [OUT_WIDTH-1:0]    out_x_motion,
  output logic                           out_y_valid,
  output logic signed [OUT_WIDTH-1:0]    out_y_motion,
  output logic                           out_button_changed,
  output logic                           out_button_pressed
);

  tas_pkg::tas_cmd_t  cmd;
  tas_pkg::tas_stat_t stat;

  // sequencer
  tas_ctrl #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  tas_datapath #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH),
    .OUT_WIDTH       (OUT_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata),
    .in_left_count      (in_left_count),
    .in_right_count     (in_right_count),
    .in_up_count        (in_up_count),
    .in_down_count      (in_down_count),
    .in_status_byte     (in_status_byte),
    .in_elapsed_time    (in_elapsed_time),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_x_valid        (out_x_valid),
    .out_x_motion       (out_x_motion),
    .out_y_valid        (out_y_valid),
    .out_y_motion       (out_y_motion),
    .out_button_changed (out_button_changed),
    .out_button_pressed (out_button_pressed)
  );

endmodule

/* sv/tas_checker.sv */
// ----------------------------------------------------------------------------
// tas_checker: port-level checks
// Concurrent checks on the top level's ports, attached by bind.
// ----------------------------------------------------------------------------
module tas_checker #(
  parameter int OUT_WIDTH = tas_pkg::OUT_WIDTH_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_x_valid,
  input logic [OUT_WIDTH-1:0] out_x_motion,
  input logic                 out_y_valid,
  input logic [OUT_WIDTH-1:0] out_y_motion,
  input logic                 out_button_changed,
  input logic                 out_button_pressed
);

  // no result is shown right after reset
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x_valid) &&
      $stable(out_x_motion) && $stable(out_y_valid) && $stable(out_y_motion) &&
      $stable(out_button_changed) && $stable(out_button_pressed))
    else $error("stalled result changed");

  // an idle axis reports zero motion
  a_x_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_x_valid |-> out_x_motion == '0)
    else $error("x motion without x movement");

  a_y_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_y_valid |-> out_y_motion == '0)
    else $error("y motion without y movement");

  // one item in work at a time
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in work");

endmodule

bind trackball_accel_smoother tas_checker #(
  .OUT_WIDTH (OUT_WIDTH)
) u_tas_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_x_valid        (out_x_valid),
  .out_x_motion       (out_x_motion),
  .out_y_valid        (out_y_valid),
  .out_y_motion       (out_y_motion),
  .out_button_changed (out_button_changed),
  .out_button_pressed (out_button_pressed)
);

/* sim/tas_checker.sv */
// ----------------------------------------------------------------------------
// tas_scoreboard: motion report predictor and scoreboard
// Watches the config port and both channels of the trackball smoother. Each
// input transfer is run through a cycle-free model of the gain, smoothing and
// switch logic; each output transfer is compared field by field against the
// oldest predicted report.
// ----------------------------------------------------------------------------
module tas_scoreboard
  import tas_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [7:0]                  in_left_count,
  input  logic [7:0]                  in_right_count,
  input  logic [7:0]                  in_up_count,
  input  logic [7:0]                  in_down_count,
  input  logic [7:0]                  in_status_byte,
  input  logic [15:0]                 in_elapsed_time,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        out_x_valid,
  input  logic signed [OUT_WIDTH_DEF-1:0] out_x_motion,
  input  logic                        out_y_valid,
  input  logic signed [OUT_WIDTH_DEF-1:0] out_y_motion,
  input  logic                        out_button_changed,
  input  logic                        out_button_pressed,
  output int                          fail_count,
  output int                          pending
);

  localparam int DEPTH = EXP_DEPTH_DEF;
  localparam int OUT_W = OUT_WIDTH_DEF;
  localparam longint MOTION_MAX = (longint'(1) <<< (OUT_W - 1)) - 1;
  localparam longint MOTION_MIN = -(longint'(1) <<< (OUT_W - 1));

  typedef struct {
    logic                    x_valid;
    logic signed [OUT_W-1:0] x_motion;
    logic                    y_valid;
    logic signed [OUT_W-1:0] y_motion;
    logic                    button_changed;
    logic                    button_pressed;
  } motion_report_t;

  motion_report_t awaited_reports[$];

  // register shadows
  logic [7:0] speed_reg;
  logic [7:0] window_reg;
  logic [9:0] alpha_reg;
  logic [7:0] mask_reg;

  // smoother state
  longint prev_x;
  longint prev_y;
  logic   prev_pressed;

  logic [ENTRY_W-1:0] decay_rom [DEPTH];
  int                 mismatches;

  // exp(-3i/DEPTH) in Q1.8: Q31 series to order 8, squared four times
  function automatic logic [ENTRY_W-1:0] decay_entry(int unsigned i);
    longint unsigned y;
    longint unsigned acc;
    longint unsigned term;
    y    = (64'd3 * i * 64'h8000_0000) / (64'd16 * DEPTH);
    acc  = 64'h8000_0000;
    term = 64'h8000_0000;
    for (int k = 1; k <= 8; k++) begin
      term = ((term * y) >> 31) / k;
      acc  = (k % 2 == 1) ? acc - term : acc + term;
    end
    repeat (4) acc = (acc * acc) >> 31;
    return ENTRY_W'((acc + (64'd1 << 22)) >> 23);
  endfunction

  initial begin
    for (int i = 0; i < DEPTH; i++) decay_rom[i] = decay_entry(i);
  end

  // blend one axis toward the new value, truncate toward zero, saturate
  function automatic longint blend_axis(longint scaled, longint prev);
    longint a;
    longint v;
    a = longint'(alpha_reg);
    v = (a * scaled + (256 - a) * prev) / 256;
    if (v > MOTION_MAX) v = MOTION_MAX;
    if (v < MOTION_MIN) v = MOTION_MIN;
    return v;
  endfunction

  // report for one poll; updates the smoother state
  function automatic motion_report_t predict_report(
    logic [7:0] left, logic [7:0] right, logic [7:0] up, logic [7:0] down,
    logic [7:0] status, logic [15:0] elapsed);
    motion_report_t rpt;
    longint         dx;
    longint         dy;
    longint         gain;
    int unsigned    idx;
    logic           pressed;
    dx      = longint'(right) - longint'(left);
    dy      = longint'(down) - longint'(up);
    pressed = (status & mask_reg) != 8'd0;
    rpt.x_valid  = dx != 0;
    rpt.y_valid  = dy != 0;
    rpt.x_motion = '0;
    rpt.y_motion = '0;
    if (dx != 0 || dy != 0) begin
      gain = 256;
      if (elapsed < window_reg) begin
        idx = (int'(elapsed) * DEPTH) / int'(window_reg);
        if (idx >= DEPTH) idx = DEPTH - 1;
        gain = 256 + (longint'(speed_reg) - 1) * longint'(decay_rom[idx]);
      end
      prev_x = blend_axis((dx * gain) / 256, prev_x);
      prev_y = blend_axis((dy * gain) / 256, prev_y);
      if (dx != 0) rpt.x_motion = OUT_W'(prev_x);
      if (dy != 0) rpt.y_motion = OUT_W'(prev_y);
    end
    rpt.button_changed = pressed != prev_pressed;
    rpt.button_pressed = pressed;
    prev_pressed       = pressed;
    return rpt;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    motion_report_t want;
    if (!rst_n) begin
      speed_reg    = PEAK_MULT_RST;
      window_reg   = ACCEL_WINDOW_RST;
      alpha_reg    = SMOOTH_GAIN_RST;
      mask_reg     = SWITCH_MASK_RST;
      prev_x       = 0;
      prev_y       = 0;
      prev_pressed = 1'b0;
      awaited_reports.delete();
    end else begin
      // register writes land before any transfer at the same edge
      if (cfg_we) begin
        case (cfg_addr)
          CFG_PEAK_MULT:    speed_reg  = cfg_wdata[7:0];
          CFG_ACCEL_WINDOW: window_reg = cfg_wdata[7:0];
          CFG_SMOOTH_GAIN:  alpha_reg  = cfg_wdata[9:0];
          CFG_SWITCH_MASK:  mask_reg   = cfg_wdata[7:0];
          default: ;
        endcase
      end
      // input transfer: predict
      if (in_valid && !in_stall)
        awaited_reports.push_back(predict_report(in_left_count, in_right_count,
          in_up_count, in_down_count, in_status_byte, in_elapsed_time));
      // output transfer: compare with oldest prediction
      if (out_valid && !out_stall) begin
        if (awaited_reports.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected report, expected none actual x=%0d y=%0d",
                   $time, out_x_motion, out_y_motion);
        end else begin
          want = awaited_reports.pop_front();
          check_field("x_valid", want.x_valid, out_x_valid);
          check_field("x_motion", want.x_motion, out_x_motion);
          check_field("y_valid", want.y_valid, out_y_valid);
          check_field("y_motion", want.y_motion, out_y_motion);
          check_field("button_changed", want.button_changed, out_button_changed);
          check_field("button_pressed", want.button_pressed, out_button_pressed);
        end
      end
    end
    pending    <= awaited_reports.size();
    fail_count <= mismatches;
  end

  initial begin
    mismatches = 0;
    pending    = 0;
    fail_count = 0;
  end

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench top for trackball_accel_smoother
// Drives directed polls (count extremes, acceleration window edges, switch
// mask, saturation, zero window and zero speed) and then random polls over
// several register settings and idle/stall mixes, including a long output
// hold-off. Checking is done by tas_scoreboard; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import tas_pkg::*;

  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 5000;
  localparam int PHASE_POLLS  = 225;
  localparam int RANDOM_PHASES = 8;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic [7:0] in_left_count;
  logic [7:0] in_right_count;
  logic [7:0] in_up_count;
  logic [7:0] in_down_count;
  logic [7:0] in_status_byte;
  logic [15:0] in_elapsed_time;
  logic out_valid;
  logic out_stall;
  logic out_x_valid;
  logic signed [OUT_WIDTH_DEF-1:0] out_x_motion;
  logic out_y_valid;
  logic signed [OUT_WIDTH_DEF-1:0] out_y_motion;
  logic out_button_changed;
  logic out_button_pressed;

  int fail_count;
  int pending;
  int idle_pct;
  int stall_pct;
  bit hold_req;
  int quiet_cycles;
  logic [7:0] cur_window;

  // corner register settings for the first random phases
  logic [7:0] speed_set  [4] = '{8'd25, 8'd255, 8'd0, 8'd1};
  logic [7:0] window_set [4] = '{8'd5, 8'd255, 8'd1, 8'd0};
  logic [9:0] alpha_set  [4] = '{10'd333, 10'd1023, 10'd0, 10'd512};
  logic [7:0] mask_set   [4] = '{8'd128, 8'd255, 8'd0, 8'd1};

  trackball_accel_smoother DUT (.*);

  tas_scoreboard report_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog: cycles without any transfer
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // offer one poll, return at the edge where it transfers
  task automatic push_poll(logic [7:0] left, logic [7:0] right, logic [7:0] up,
                           logic [7:0] down, logic [7:0] status, logic [15:0] elapsed);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_left_count   <= left;
    in_right_count  <= right;
    in_up_count     <= up;
    in_down_count   <= down;
    in_status_byte  <= status;
    in_elapsed_time <= elapsed;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop offering and wait for every predicted report
  task automatic drain_reports();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(logic [7:0] speed, logic [7:0] window,
                            logic [9:0] alpha, logic [7:0] mask);
    drain_reports();
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_PEAK_MULT;
    cfg_wdata <= CFG_DATA_W'(speed);
    @(posedge clk);
    cfg_addr  <= CFG_ACCEL_WINDOW;
    cfg_wdata <= CFG_DATA_W'(window);
    @(posedge clk);
    cfg_addr  <= CFG_SMOOTH_GAIN;
    cfg_wdata <= alpha;
    @(posedge clk);
    cfg_addr  <= CFG_SWITCH_MASK;
    cfg_wdata <= CFG_DATA_W'(mask);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_window = window;
  endtask

  // random poll: mostly motion, some still, some single-axis
  task automatic random_poll();
    logic [7:0]  l, r, u, d;
    logic [15:0] t;
    int          kind;
    kind = $urandom_range(99);
    l = 8'($urandom_range(255));
    r = 8'($urandom_range(255));
    u = 8'($urandom_range(255));
    d = 8'($urandom_range(255));
    if (kind < 10) begin
      r = l;
      d = u;
    end else if (kind < 20) begin
      d = u;
    end else if (kind < 30) begin
      r = l;
    end else if (kind < 45) begin
      // small movement
      l = 8'($urandom_range(3));
      r = 8'($urandom_range(3));
      u = 8'($urandom_range(3));
      d = 8'($urandom_range(3));
    end
    if ($urandom_range(3) == 0) t = 16'($urandom_range(65535));
    else t = 16'($urandom_range(cur_window));
    push_poll(l, r, u, d, 8'($urandom_range(255)), t);
  endtask

  initial begin
    hold_req        = 1'b0;
    idle_pct        = 0;
    stall_pct       = 0;
    cur_window      = ACCEL_WINDOW_RST;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_addr        <= CFG_PEAK_MULT;
    cfg_wdata       <= '0;
    in_valid        <= 1'b0;
    in_left_count   <= '0;
    in_right_count  <= '0;
    in_up_count     <= '0;
    in_down_count   <= '0;
    in_status_byte  <= '0;
    in_elapsed_time <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, count extremes and window edges
    push_poll(8'd0, 8'd0, 8'd0, 8'd0, 8'h00, 16'd0);      // still, report without motion
    push_poll(8'd0, 8'd255, 8'd0, 8'd0, 8'h80, 16'd0);    // full right, peak gain, press
    push_poll(8'd255, 8'd0, 8'd0, 8'd0, 8'h80, 16'd0);    // full left, press held
    push_poll(8'd0, 8'd0, 8'd0, 8'd255, 8'h00, 16'd1);    // full down, release
    push_poll(8'd0, 8'd0, 8'd255, 8'd0, 8'h7f, 16'd4);    // full up, masked-out bits
    push_poll(8'd10, 8'd10, 8'd20, 8'd20, 8'hff, 16'd3);  // still: keeps previous
    push_poll(8'd0, 8'd1, 8'd0, 8'd0, 8'hff, 16'd5);      // elapsed at window: unity gain
    push_poll(8'd0, 8'd0, 8'd0, 8'd1, 8'h00, 16'hffff);
    push_poll(8'd255, 8'd255, 8'd0, 8'd255, 8'h00, 16'h8000);
    push_poll(8'd3, 8'd7, 8'd9, 8'd2, 8'h80, 16'd2);

    // directed: peak gain and alpha, saturation both ways
    write_regs(8'd255, 8'd255, 10'd1023, 8'd255);
    push_poll(8'd0, 8'd255, 8'd0, 8'd255, 8'h01, 16'd0);
    push_poll(8'd255, 8'd0, 8'd255, 8'd0, 8'h01, 16'd0);
    push_poll(8'd0, 8'd255, 8'd255, 8'd0, 8'h00, 16'd254);
    push_poll(8'd0, 8'd0, 8'd0, 8'd0, 8'h00, 16'd0);

    // directed: zero window
    write_regs(8'd0, 8'd0, 10'd512, 8'd0);
    push_poll(8'd0, 8'd255, 8'd0, 8'd0, 8'hff, 16'd0);
    push_poll(8'd255, 8'd0, 8'd0, 8'd255, 8'hff, 16'd0);

    // directed: zero speed gives gain below one, alpha zero
    write_regs(8'd0, 8'd200, 10'd0, 8'd1);
    push_poll(8'd0, 8'd200, 8'd100, 8'd0, 8'h01, 16'd0);
    push_poll(8'd50, 8'd0, 8'd0, 8'd50, 8'hfe, 16'd199);

    // random phases: fixed corner settings first, then random settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 4) write_regs(speed_set[p], window_set[p], alpha_set[p], mask_set[p]);
      else write_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                      10'($urandom_range(1023)), 8'($urandom_range(255)));
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 75; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 75; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      // long output hold-off while polls keep coming
      if (p == 0) hold_req = 1'b1;
      for (int i = 0; i < PHASE_POLLS; i++) random_poll();
    end

    drain_reports();
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
